@@ sv/tsb_pkg.sv @@
// tsb_pkg: shared constants, types and helpers for the tinted sprite blender
// no dependencies; used by tsb_front, tsb_fifo, tsb_back, the top and the bench
`default_nettype none

package tsb_pkg;

    // palette store
    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
    localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_DEPTH);

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int Q_AW   = $clog2(QDEPTH);
    localparam int Q_CW   = $clog2(QDEPTH + 1);
    localparam logic [Q_CW-1:0] Q_FULL  = Q_CW'(QDEPTH);
    localparam logic [Q_CW:0]   Q_LIMIT = (Q_CW + 1)'(QDEPTH);
    localparam logic [Q_AW-1:0] Q_LAST  = Q_AW'(QDEPTH - 1);

    // item opcodes
    localparam logic [1:0] OP_PAL_WR   = 2'd0;
    localparam logic [1:0] OP_PIX_IDX  = 2'd1;
    localparam logic [1:0] OP_PIX_ARGB = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_TINT_RED   = 2'd0;
    localparam logic [1:0] CFG_TINT_GREEN = 2'd1;
    localparam logic [1:0] CFG_TINT_BLUE  = 2'd2;
    localparam logic [1:0] CFG_TINT_ALPHA = 2'd3;

    localparam logic [7:0]  CHAN_MAX = 8'hFF;
    localparam logic [23:0] RGB_ZERO = 24'h000000;

    typedef struct packed {
        logic        draw;
        logic [31:0] src;
        logic [31:0] dst;
    } t_job;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_tint;

    // floor(x / 255), exact for any product of two 8-bit values
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
        return s[15:8];
    endfunction

endpackage

`default_nettype wire

@@ sv/tsb_pix_if.sv @@
// tsb_pix_if: pixel item channel (valid, ready and item fields)
// no dependencies
`default_nettype none

interface tsb_pix_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  pixel_index;
    logic [31:0] source_color;
    logic [31:0] dest_pixel;

    modport source (output valid, output opcode, output pixel_index,
                    output source_color, output dest_pixel, input ready);
    modport sink   (input valid, input opcode, input pixel_index,
                    input source_color, input dest_pixel, output ready);
endinterface

`default_nettype wire

@@ sv/tsb_res_if.sv @@
// tsb_res_if: result channel (valid, ready and result fields)
// no dependencies
`default_nettype none

interface tsb_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] new_dest_pixel;
    logic        dest_written;

    modport source (output valid, output new_dest_pixel, output dest_written,
                    input ready);
    modport sink   (input valid, input new_dest_pixel, input dest_written,
                    output ready);
endinterface

`default_nettype wire

@@ sv/tsb_cfg_if.sv @@
// tsb_cfg_if: configuration write channel (valid, ready, index, data)
// no dependencies
`default_nettype none

interface tsb_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/tsb_ram.sv @@
// tsb_ram: generic single-port ram with registered read
// no dependencies
`default_nettype none

module tsb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

@@ sv/tsb_front.sv @@
// tsb_front: accepts items, keeps the palette, builds the source word per pixel
// depends on tsb_pkg, tsb_pix_if, tsb_ram
`default_nettype none

module tsb_front (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    tsb_pix_if.sink                     i_pix,
    input  wire logic [tsb_pkg::Q_CW-1:0] i_q_count,
    output logic                        o_push,
    output tsb_pkg::t_job               o_job
);
    logic                 w_acc;
    logic                 w_in_range;
    logic [tsb_pkg::Q_CW:0] w_fill;
    logic [23:0]          w_rgb;

    logic        r_fv;
    logic [1:0]  r_op;
    logic        r_idx_nz;
    logic        r_in_range;
    logic [31:0] r_src;
    logic [31:0] r_dst;

    // the front stage always drains into the queue, so count it as occupied
    assign w_fill      = {1'b0, i_q_count} + {{tsb_pkg::Q_CW{1'b0}}, r_fv};
    assign i_pix.ready = (w_fill < tsb_pkg::Q_LIMIT);
    assign w_acc       = i_pix.valid && i_pix.ready;
    assign w_in_range  = ({1'b0, i_pix.pixel_index} < tsb_pkg::PAL_LIMIT);

    tsb_ram #(
        .WIDTH (24),
        .DEPTH (tsb_pkg::PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (w_acc && (i_pix.opcode == tsb_pkg::OP_PAL_WR) && w_in_range),
        .i_addr  (i_pix.pixel_index[tsb_pkg::PAL_AW-1:0]),
        .i_wdata (i_pix.source_color[23:0]),
        .o_rdata (w_rgb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_op       <= i_pix.opcode;
            r_idx_nz   <= (i_pix.pixel_index != 8'd0);
            r_in_range <= w_in_range;
            r_src      <= i_pix.source_color;
            r_dst      <= i_pix.dest_pixel;
        end
    end

    always_comb begin
        o_job.dst = r_dst;
        case (r_op)
            tsb_pkg::OP_PIX_IDX: begin
                o_job.draw = r_idx_nz;
                o_job.src  = {tsb_pkg::CHAN_MAX, r_in_range ? w_rgb : tsb_pkg::RGB_ZERO};
            end
            tsb_pkg::OP_PIX_ARGB: begin
                o_job.draw = (r_src[31:24] != 8'd0);
                o_job.src  = r_src;
            end
            default: begin
                o_job.draw = 1'b0;
                o_job.src  = r_src;
            end
        endcase
    end

    assign o_push = r_fv;
endmodule

`default_nettype wire

@@ sv/tsb_fifo.sv @@
// tsb_fifo: short job queue between front and back
// depends on tsb_pkg
`default_nettype none

module tsb_fifo (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_push,
    input  wire tsb_pkg::t_job            i_job,
    input  wire logic                     i_pop,
    output logic                          o_valid,
    output tsb_pkg::t_job                 o_job,
    output logic [tsb_pkg::Q_CW-1:0]      o_count
);
    tsb_pkg::t_job               r_mem [tsb_pkg::QDEPTH];
    logic [tsb_pkg::Q_AW-1:0]    r_wp;
    logic [tsb_pkg::Q_AW-1:0]    r_rp;
    logic [tsb_pkg::Q_CW-1:0]    r_cnt;
    logic [tsb_pkg::Q_AW-1:0]    n_wp;
    logic [tsb_pkg::Q_AW-1:0]    n_rp;
    logic [tsb_pkg::Q_CW-1:0]    n_cnt;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == tsb_pkg::Q_LAST) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == tsb_pkg::Q_LAST) ? '0 : r_rp + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign o_count = r_cnt;
endmodule

`default_nettype wire

@@ sv/tsb_back.sv @@
// tsb_back: tint, premultiply and source-over pipeline with output register
// depends on tsb_pkg, tsb_res_if
`default_nettype none

module tsb_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire tsb_pkg::t_job i_job,
    output logic               o_pop,
    input  wire tsb_pkg::t_tint i_tint,
    tsb_res_if.source          o_res
);
    logic [3:0][7:0] w_src;
    logic [3:0][7:0] w_tv;
    logic en1, en2, en3, en4;

    // stage 1: tint products
    logic             r_v1;
    logic [3:0][15:0] r_p1, n_p1;
    logic [31:0]      r_dst1;
    logic             r_draw1;
    // stage 2: premultiply products
    logic             r_v2;
    logic [2:0][15:0] r_q2, n_q2;
    logic [7:0]       r_a2, n_a2;
    logic [31:0]      r_dst2;
    logic             r_draw2;
    // stage 3: destination times inverse alpha
    logic             r_v3;
    logic [3:0][7:0]  r_s3, n_s3;
    logic [3:0][15:0] r_m3, n_m3;
    logic [31:0]      r_dst3;
    logic             r_draw3;
    // output register
    logic             r_ov;
    logic [31:0]      r_res, n_res;
    logic             r_wr, n_wr;

    logic [7:0]       w_inv;
    logic [3:0][7:0]  w_blend;
    logic [8:0]       w_sum;

    assign en4   = !r_ov || o_res.ready;
    assign en3   = !r_v3 || en4;
    assign en2   = !r_v2 || en3;
    assign en1   = !r_v1 || en2;
    assign o_pop = i_valid && en1;

    assign w_src = i_job.src;
    assign w_tv  = i_tint;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n_p1[c] = 16'(w_src[c]) * 16'(w_tv[c]);
        end
    end

    // premultiplying at alpha 255 is exact and alpha 0 is never drawn,
    // so no bypass is needed for those
    always_comb begin
        n_a2 = tsb_pkg::div255(r_p1[3]);
        for (int c = 0; c < 3; c++) begin
            n_q2[c] = 16'(tsb_pkg::div255(r_p1[c])) * 16'(n_a2);
        end
    end

    always_comb begin
        w_inv = tsb_pkg::CHAN_MAX - r_a2;
        for (int c = 0; c < 3; c++) begin
            n_s3[c] = tsb_pkg::div255(r_q2[c]);
        end
        n_s3[3] = r_a2;
        for (int c = 0; c < 4; c++) begin
            n_m3[c] = 16'(r_dst2[8*c +: 8]) * 16'(w_inv);
        end
    end

    always_comb begin
        w_sum = '0;
        for (int c = 0; c < 4; c++) begin
            w_sum      = {1'b0, r_s3[c]} + {1'b0, tsb_pkg::div255(r_m3[c])};
            w_blend[c] = w_sum[8] ? tsb_pkg::CHAN_MAX : w_sum[7:0];
        end
        if (!r_draw3 || (r_s3[3] == 8'd0)) begin
            n_res = r_dst3;
            n_wr  = 1'b0;
        end else if (r_s3[3] == tsb_pkg::CHAN_MAX) begin
            n_res = r_s3;
            n_wr  = 1'b1;
        end else begin
            n_res = w_blend;
            n_wr  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_ov <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_p1    <= n_p1;
            r_dst1  <= i_job.dst;
            r_draw1 <= i_job.draw;
        end
        if (en2) begin
            r_q2    <= n_q2;
            r_a2    <= n_a2;
            r_dst2  <= r_dst1;
            r_draw2 <= r_draw1;
        end
        if (en3) begin
            r_s3    <= n_s3;
            r_m3    <= n_m3;
            r_dst3  <= r_dst2;
            r_draw3 <= r_draw2;
        end
        if (en4) begin
            r_res <= n_res;
            r_wr  <= n_wr;
        end
    end

    assign o_res.valid          = r_ov;
    assign o_res.new_dest_pixel = r_res;
    assign o_res.dest_written   = r_wr;
endmodule

`default_nettype wire

@@ sv/tinted_sprite_pixel_blend.sv @@
// tinted_sprite_pixel_blend: throughput one item per cycle unless the result side
// stalls, set by the single-port palette ram and the four-stage blend pipeline behind
// a four-entry queue
// reset (synchronous, active low) empties the queue and pipeline and sets all
// tint factors to 255; palette contents stay undefined until written
// depends on tsb_pkg, tsb_pix_if, tsb_res_if, tsb_cfg_if, tsb_front, tsb_fifo, tsb_back
`default_nettype none

module tinted_sprite_pixel_blend (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tsb_pix_if.sink   i_pix,
    tsb_cfg_if.sink   i_cfg,
    tsb_res_if.source o_res
);
    // tint registers, to be written only while the block is idle; the block itself does not enforce this
    tsb_pkg::t_tint r_tint;

    // front to queue
    logic          w_push;
    tsb_pkg::t_job w_push_job;
    // queue to back
    logic                     w_q_valid;
    logic                     w_pop;
    tsb_pkg::t_job            w_q_job;
    logic [tsb_pkg::Q_CW-1:0] w_q_count;

    // configuration writes never stall
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tint.r <= tsb_pkg::CHAN_MAX;
            r_tint.g <= tsb_pkg::CHAN_MAX;
            r_tint.b <= tsb_pkg::CHAN_MAX;
            r_tint.a <= tsb_pkg::CHAN_MAX;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                tsb_pkg::CFG_TINT_RED:   r_tint.r <= i_cfg.data;
                tsb_pkg::CFG_TINT_GREEN: r_tint.g <= i_cfg.data;
                tsb_pkg::CFG_TINT_BLUE:  r_tint.b <= i_cfg.data;
                tsb_pkg::CFG_TINT_ALPHA: r_tint.a <= i_cfg.data;
                default:                 r_tint   <= r_tint;
            endcase
        end
    end

    // front: transfer, palette access, source word and draw decision
    tsb_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pix     (i_pix),
        .i_q_count (w_q_count),
        .o_push    (w_push),
        .o_job     (w_push_job)
    );

    // queue lets the front keep taking pixels while the result side stalls, until it is full
    tsb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_job   (w_q_job),
        .o_count (w_q_count)
    );

    // back: tint, premultiply, source-over, saturate, output register
    tsb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_job   (w_q_job),
        .o_pop   (w_pop),
        .i_tint  (r_tint),
        .o_res   (o_res)
    );

    // the front reserves queue space, so a push never meets a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_count == tsb_pkg::Q_FULL) |-> !w_push)
        else $error("push into full job queue");

    // a full queue must hold off new pixel transfers
    a_full_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_count == tsb_pkg::Q_FULL) |-> !i_pix.ready)
        else $error("input ready while job queue full");

    // the back only pops entries that are there
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("pop from empty job queue");

    // every accepted transfer is pushed into the queue in the cycle after it
    a_push_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> w_push)
        else $error("accepted item did not reach the queue");
endmodule

`default_nettype wire

@@ bench/tinted_sprite_pixel_blend_tb.sv @@
// self-checking bench for tinted_sprite_pixel_blend: directed rows then random phases,
// every result compared against an in-bench compositing predictor or the expectation typed in its row
// depends on tsb_pkg, tsb_pix_if, tsb_res_if, tsb_cfg_if and the block itself
module tinted_sprite_pixel_blend_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsb_pkg::*;

    localparam int N_ITEMS      = 900;  // random items that the block acts on
    localparam int QUIET_TAIL   = 120;  // closing stretch with no idling on either side
    localparam int REPORT_LIMIT = 10;
    localparam int DRAIN_PAD    = 8;    // settling margin after the last expected result

    // opcode three carries no operation and must leave the destination alone
    localparam logic [1:0] OP_RESERVED = 2'd3;

    typedef enum logic { ROW_PIXEL, ROW_TINT } row_kind_e;

    typedef struct packed {
        row_kind_e   kind;
        logic [1:0]  op;
        logic [7:0]  idx;
        logic [31:0] src;
        logic [31:0] dst;
        logic        typed;      // expectation written in the row itself
        logic [31:0] want_pix;
        logic        want_wr;
        logic [1:0]  cfg_index;
        logic [7:0]  cfg_value;
    } dir_row_t;

    typedef struct packed {
        logic [31:0] pix;
        logic        wr;
    } dest_result_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tsb_pix_if pix_if ();
    tsb_cfg_if cfg_if ();
    tsb_res_if res_if ();

    tinted_sprite_pixel_blend dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    always #5 i_clk = ~i_clk;

    // predictor state: tint factors and palette as seen at each transfer
    t_tint        tint_q;
    logic [23:0]  pal_rgb   [PALETTE_DEPTH];
    // palette entries the stimulus has already written, so reads stay legal
    bit           pal_known [PALETTE_DEPTH];

    dest_result_t predicted_dest [$];
    dest_result_t predicted, seen;
    dir_row_t     directed_rows [$];
    int           failures = 0;

    // side band that travels with the pixel on the channel: typed expectation
    logic         drv_typed;
    logic [31:0]  drv_want_pix;
    logic         drv_want_wr;

    // idling control shared by sender and receiver
    bit           idling;
    bit           quiet_tail;
    int           res_burst = 0;
    bit           res_stall = 1'b0;

    // floor(c * f / 255)
    function automatic logic [7:0] mul_div255(input logic [7:0] c, input logic [7:0] f);
        int unsigned p;
        p = 32'(c) * 32'(f);
        return 8'(p / 255);
    endfunction

    // one source-over channel, saturating at full scale
    function automatic logic [7:0] over_chan(input logic [7:0] s, input logic [7:0] d,
                                             input logic [7:0] inv);
        int unsigned v;
        v = 32'(s) + 32'(d) * 32'(inv) / 255;
        return (v > 255) ? CHAN_MAX : 8'(v);
    endfunction

    // works out the new destination for one item and updates the palette copy
    function automatic void composite_pixel(input logic [1:0] op, input logic [7:0] idx,
                                            input logic [31:0] src, input logic [31:0] dst,
                                            output logic [31:0] new_pix, output logic wrote);
        logic [31:0] colour;
        logic        draw;
        logic [7:0]  a, r, g, b, inv;
        new_pix = dst;
        wrote   = 1'b0;
        draw    = 1'b0;
        colour  = src;
        case (op)
            OP_PAL_WR: begin
                if (idx < PALETTE_DEPTH)
                    pal_rgb[idx] = src[23:0];
            end
            OP_PIX_IDX: begin
                if (idx != 8'd0) begin
                    colour = {CHAN_MAX, (idx < PALETTE_DEPTH) ? pal_rgb[idx] : RGB_ZERO};
                    draw   = 1'b1;
                end
            end
            OP_PIX_ARGB: draw = (src[31:24] != 8'd0);
            default: ;
        endcase
        if (draw) begin
            // tint every channel, then premultiply unless alpha is at an end
            a = mul_div255(colour[31:24], tint_q.a);
            r = mul_div255(colour[23:16], tint_q.r);
            g = mul_div255(colour[15:8],  tint_q.g);
            b = mul_div255(colour[7:0],   tint_q.b);
            if (a != 8'd0 && a != CHAN_MAX) begin
                r = mul_div255(r, a);
                g = mul_div255(g, a);
                b = mul_div255(b, a);
            end
            if (a == CHAN_MAX) begin
                new_pix = {a, r, g, b};
                wrote   = 1'b1;
            end else if (a != 8'd0) begin
                inv     = CHAN_MAX - a;
                new_pix = {over_chan(a, dst[31:24], inv), over_chan(r, dst[23:16], inv),
                           over_chan(g, dst[15:8], inv), over_chan(b, dst[7:0], inv)};
                wrote   = 1'b1;
            end
        end
    endfunction

    task automatic report_failure(input string msg);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("%s", msg);
    endtask

    // scoreboard: everything sampled on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.index)
                    CFG_TINT_RED:   tint_q.r = cfg_if.data;
                    CFG_TINT_GREEN: tint_q.g = cfg_if.data;
                    CFG_TINT_BLUE:  tint_q.b = cfg_if.data;
                    CFG_TINT_ALPHA: tint_q.a = cfg_if.data;
                    default: ;
                endcase
            end
            if (pix_if.valid && pix_if.ready) begin
                composite_pixel(pix_if.opcode, pix_if.pixel_index, pix_if.source_color,
                                pix_if.dest_pixel, predicted.pix, predicted.wr);
                // a typed row overrides the predictor but the palette copy still moves
                if (drv_typed) begin
                    predicted.pix = drv_want_pix;
                    predicted.wr  = drv_want_wr;
                end
                predicted_dest.push_back(predicted);
            end
            if (res_if.valid && res_if.ready) begin
                seen.pix = res_if.new_dest_pixel;
                seen.wr  = res_if.dest_written;
                if (predicted_dest.size() == 0) begin
                    report_failure($sformatf("result with nothing expected: %08h/%0d",
                                             seen.pix, seen.wr));
                end else begin
                    predicted = predicted_dest.pop_front();
                    if (seen.pix !== predicted.pix || seen.wr !== predicted.wr)
                        report_failure($sformatf(
                            "mismatch: new_dest_pixel exp %08h got %08h, dest_written exp %0d got %0d",
                            predicted.pix, seen.pix, predicted.wr, seen.wr));
                end
            end
        end
    end

    // result side: bursts of stall and flow, always flowing outside idling phases
    always @(negedge i_clk) begin
        if (res_burst == 0) begin
            res_stall = ($urandom_range(0, 2) == 0);
            res_burst = $urandom_range(1, 12);
        end
        res_burst--;
        res_if.ready <= !(res_stall && idling && !quiet_tail);
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] idx,
                             input logic [31:0] src, input logic [31:0] dst,
                             input logic typed, input logic [31:0] want_pix,
                             input logic want_wr);
        if (op == OP_PAL_WR)
            pal_known[idx] = 1'b1;
        @(negedge i_clk);
        pix_if.valid        <= 1'b1;
        pix_if.opcode       <= op;
        pix_if.pixel_index  <= idx;
        pix_if.source_color <= src;
        pix_if.dest_pixel   <= dst;
        drv_typed           <= typed;
        drv_want_pix        <= want_pix;
        drv_want_wr         <= want_wr;
        @(posedge i_clk);
        while (!pix_if.ready)
            @(posedge i_clk);
    endtask

    // sender gap of the given number of cycles
    task automatic hold_off(input int cycles);
        @(negedge i_clk);
        pix_if.valid <= 1'b0;
        repeat (cycles - 1)
            @(negedge i_clk);
    endtask

    // every item gives exactly one result, so an empty store means idle
    task automatic drain_pipeline();
        @(negedge i_clk);
        pix_if.valid <= 1'b0;
        while (predicted_dest.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_PAD)
            @(posedge i_clk);
    endtask

    task automatic write_tint(input logic [1:0] cfg_index, input logic [7:0] value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= cfg_index;
        cfg_if.data  <= value;
        @(posedge i_clk);
        while (!cfg_if.ready)
            @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic void add_pixel_row(input logic [1:0] op, input logic [7:0] idx,
                                          input logic [31:0] src, input logic [31:0] dst,
                                          input logic typed, input logic [31:0] want_pix,
                                          input logic want_wr);
        dir_row_t row;
        row           = '0;
        row.kind      = ROW_PIXEL;
        row.op        = op;
        row.idx       = idx;
        row.src       = src;
        row.dst       = dst;
        row.typed     = typed;
        row.want_pix  = want_pix;
        row.want_wr   = want_wr;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_tint_row(input logic [1:0] cfg_index, input logic [7:0] value);
        dir_row_t row;
        row           = '0;
        row.kind      = ROW_TINT;
        row.cfg_index = cfg_index;
        row.cfg_value = value;
        directed_rows.push_back(row);
    endfunction

    // first phase at full tint, second at zero, then a mix biased to the ends
    function automatic logic [7:0] tint_pick(input int phase);
        if (phase == 0)
            return CHAN_MAX;
        if (phase == 1)
            return 8'd0;
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return CHAN_MAX;
            2:       return 8'd1;
            3:       return 8'd254;
            default: return 8'($urandom);
        endcase
    endfunction

    // a nonzero palette entry that has been written already
    function automatic logic [7:0] known_index();
        logic [7:0] cand;
        for (int t = 0; t < 256; t++) begin
            cand = 8'($urandom_range(1, 255));
            if (pal_known[cand])
                return cand;
        end
        return 8'd1;
    endfunction

    initial begin : stimulus
        dir_row_t   row;
        int         sent;
        int         phase;
        int         phase_len;
        int         done;
        int         pick;
        logic [1:0] op;
        logic [7:0] idx;
        logic [31:0] src, dst;

        // every input known from time zero
        pix_if.valid        = 1'b0;
        pix_if.opcode       = OP_PAL_WR;
        pix_if.pixel_index  = 8'd0;
        pix_if.source_color = 32'd0;
        pix_if.dest_pixel   = 32'd0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = CFG_TINT_RED;
        cfg_if.data         = 8'd0;
        res_if.ready        = 1'b0;
        drv_typed           = 1'b0;
        drv_want_pix        = 32'd0;
        drv_want_wr         = 1'b0;
        idling              = 1'b0;
        quiet_tail          = 1'b0;
        tint_q              = {CHAN_MAX, CHAN_MAX, CHAN_MAX, CHAN_MAX};
        for (int k = 0; k < PALETTE_DEPTH; k++) begin
            pal_known[k] = 1'b0;
            pal_rgb[k]   = RGB_ZERO;
        end

        repeat (10)
            @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // palette loads, result is the destination untouched
        add_pixel_row(OP_PAL_WR, 8'd1,   32'hAB123456, 32'h11223344, 1'b1, 32'h11223344, 1'b0);
        add_pixel_row(OP_PAL_WR, 8'd255, 32'h00FFFFFF, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 1'b0);
        add_pixel_row(OP_PAL_WR, 8'd2,   32'hFF000000, 32'h00000000, 1'b1, 32'h00000000, 1'b0);
        add_pixel_row(OP_PAL_WR, 8'd0,   32'h00808080, 32'h80808080, 1'b1, 32'h80808080, 1'b0);
        // indexed at full tint: opaque colour replaces the destination
        add_pixel_row(OP_PIX_IDX, 8'd1,   32'h0, 32'hDEADBEEF, 1'b1, 32'hFF123456, 1'b1);
        add_pixel_row(OP_PIX_IDX, 8'd255, 32'hFFFFFFFF, 32'h0, 1'b1, 32'hFFFFFFFF, 1'b1);
        add_pixel_row(OP_PIX_IDX, 8'd2,   32'h0, 32'hFFFFFFFF, 1'b1, 32'hFF000000, 1'b1);
        // index zero is transparent
        add_pixel_row(OP_PIX_IDX, 8'd0, 32'hFFFFFFFF, 32'h01020304, 1'b1, 32'h01020304, 1'b0);
        // direct: alpha zero skipped, alpha full replaces, partial blends; reserved opcode leaves the destination
        add_pixel_row(OP_PIX_ARGB, 8'd0, 32'h00FFFFFF, 32'h55667788, 1'b1, 32'h55667788, 1'b0);
        add_pixel_row(OP_PIX_ARGB, 8'd0, 32'hFF102030, 32'hAAAAAAAA, 1'b1, 32'hFF102030, 1'b1);
        add_pixel_row(OP_PIX_ARGB, 8'hFF, 32'h80FFFFFF, 32'hFFFFFFFF, 1'b0, 32'h0, 1'b0);
        add_pixel_row(OP_PIX_ARGB, 8'd0, 32'h01FFFFFF, 32'h00000000, 1'b0, 32'h0, 1'b0);
        add_pixel_row(OP_PIX_ARGB, 8'd0, 32'hFE7F3F1F, 32'h80402010, 1'b0, 32'h0, 1'b0);
        add_pixel_row(OP_RESERVED, 8'hFF, 32'hFFFFFFFF, 32'h0F0F0F0F, 1'b1, 32'h0F0F0F0F, 1'b0);
        add_pixel_row(OP_PIX_ARGB, 8'd0, 32'h00000000, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 1'b0);
        // alpha tint of one drops alpha 254 to zero, so nothing is drawn
        add_tint_row(CFG_TINT_ALPHA, 8'd1);
        add_pixel_row(OP_PIX_ARGB, 8'd0, 32'hFEFFFFFF, 32'h12345678, 1'b1, 32'h12345678, 1'b0);
        add_pixel_row(OP_PIX_ARGB, 8'd0, 32'hFF808080, 32'hFFFFFFFF, 1'b0, 32'h0, 1'b0);
        // all tints at zero: every draw vanishes
        add_tint_row(CFG_TINT_RED,   8'd0);
        add_tint_row(CFG_TINT_GREEN, 8'd0);
        add_tint_row(CFG_TINT_BLUE,  8'd0);
        add_tint_row(CFG_TINT_ALPHA, 8'd0);
        add_pixel_row(OP_PIX_IDX, 8'd1, 32'h0, 32'h12345678, 1'b1, 32'h12345678, 1'b0);
        add_pixel_row(OP_PIX_ARGB, 8'd0, 32'hFFFFFFFF, 32'h87654321, 1'b1, 32'h87654321, 1'b0);
        // mixed channel tints
        add_tint_row(CFG_TINT_GREEN, 8'd128);
        add_tint_row(CFG_TINT_BLUE,  CHAN_MAX);
        add_tint_row(CFG_TINT_ALPHA, CHAN_MAX);
        add_pixel_row(OP_PIX_ARGB, 8'd0, 32'hFFFFFFFF, 32'h00000000, 1'b0, 32'h0, 1'b0);
        add_pixel_row(OP_PIX_IDX, 8'd1, 32'h0, 32'hFFFFFFFF, 1'b0, 32'h0, 1'b0);
        add_tint_row(CFG_TINT_ALPHA, 8'd254);
        add_pixel_row(OP_PIX_ARGB, 8'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 32'h0, 1'b0);
        add_pixel_row(OP_PIX_IDX, 8'd255, 32'h0, 32'h7F7F7F7F, 1'b0, 32'h0, 1'b0);

        // tint writes only once the pipeline has emptied
        for (int k = 0; k < directed_rows.size(); k++) begin
            row = directed_rows[k];
            if (row.kind == ROW_TINT) begin
                drain_pipeline();
                write_tint(row.cfg_index, row.cfg_value);
            end else begin
                send_item(row.op, row.idx, row.src, row.dst, row.typed, row.want_pix,
                          row.want_wr);
            end
        end

        // random phases, each with fresh tints and its own idling mode
        sent  = 0;
        phase = 0;
        while (sent < N_ITEMS) begin
            drain_pipeline();
            quiet_tail = (N_ITEMS - sent <= QUIET_TAIL);
            idling     = !quiet_tail && ($urandom_range(0, 3) != 0);
            write_tint(CFG_TINT_RED,   tint_pick(phase));
            write_tint(CFG_TINT_GREEN, tint_pick(phase));
            write_tint(CFG_TINT_BLUE,  tint_pick(phase));
            write_tint(CFG_TINT_ALPHA, tint_pick(phase));
            phase_len = quiet_tail ? N_ITEMS - sent : $urandom_range(40, 110);
            if (phase_len > N_ITEMS - sent)
                phase_len = N_ITEMS - sent;
            done = 0;
            while (done < phase_len) begin
                if (idling && $urandom_range(0, 3) == 0)
                    hold_off($urandom_range(1, 12));
                pick = $urandom_range(0, 99);
                src  = $urandom;
                dst  = $urandom;
                idx  = 8'($urandom);
                if ($urandom_range(0, 15) == 0)
                    dst = $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'h00000000;
                if (pick < 15) begin
                    op = OP_PAL_WR;
                end else if (pick < 45) begin
                    op  = OP_PIX_IDX;
                    idx = ($urandom_range(0, 9) == 0) ? 8'd0 : known_index();
                end else if (pick < 94) begin
                    op = OP_PIX_ARGB;
                    // lean on the alpha ends where the special paths live
                    case ($urandom_range(0, 9))
                        0:       src[31:24] = 8'd0;
                        1, 2:    src[31:24] = CHAN_MAX;
                        3:       src[31:24] = 8'd1;
                        4:       src[31:24] = 8'd254;
                        default: ;
                    endcase
                end else begin
                    op = OP_RESERVED;
                end
                send_item(op, idx, src, dst, 1'b0, 32'h0, 1'b0);
                if (op != OP_RESERVED) begin
                    sent++;
                    done++;
                end
            end
            phase++;
        end

        drain_pipeline();
        if (failures == 0)
            $display("PASS tinted_sprite_pixel_blend");
        else
            $display("FAIL tinted_sprite_pixel_blend");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("FAIL tinted_sprite_pixel_blend");
        $finish;
    end

endmodule
